FILE: design/tomasulo_scheduler_unit_macros.svh
// Assertion helpers for the scheduler
`ifndef TOMASULO_SCHEDULER_UNIT_MACROS_SVH
`define TOMASULO_SCHEDULER_UNIT_MACROS_SVH
// property that must hold on every clock edge out of reset
`define TS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on the same edge
`define TS_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`endif

FILE: design/ts_pkg.sv
// ----------------------------------------------------------------------------
// ts_pkg
// Shared types, constants and arithmetic helpers of the scheduler.
// ----------------------------------------------------------------------------
package ts_pkg;
  localparam int ADD_STATIONS_DEF = 8;
  localparam int MUL_STATIONS_DEF = 8;
  localparam int ARCH_REGS_DEF    = 32;
  localparam int TAG_W            = 4;
  localparam int VAL_W            = 32;
  localparam int REG_FIELD_W      = 5;
  localparam int LAT_W            = 8;
  localparam int CNT_W            = 4;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_ADDI = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [2:0] CFG_ADD_LAT = 3'd0;
  localparam logic [2:0] CFG_SUB_LAT = 3'd1;
  localparam logic [2:0] CFG_MUL_LAT = 3'd2;
  localparam logic [2:0] CFG_DIV_LAT = 3'd3;
  localparam logic [2:0] CFG_ADD_CNT = 3'd4;
  localparam logic [2:0] CFG_MUL_CNT = 3'd5;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture a request
    logic issue;     // issue phase
    logic dispatch;  // dispatch phase (starts math)
    logic finish;    // write back phase
  } ts_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic math_busy;  // math stage still busy (divider iterating, product or start pending)
  } ts_stat_t;

  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic [31:0] r;
    if (neg) begin
      if (m >= 64'h8000_0000) r = 32'h8000_0000;
      else r = 32'(-m);
    end else begin
      if (m > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r = s[31:0];
    return r;
  endfunction
endpackage

FILE: design/ts_ctrl.sv
// ----------------------------------------------------------------------------
// ts_ctrl
// Sequencer of one tick: capture, issue, dispatch, wait for math, write back.
// ----------------------------------------------------------------------------
module ts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ts_pkg::ts_stat_t stat,
  output ts_pkg::ts_cmd_t  cmd
);
  import ts_pkg::*;
  `include "tomasulo_scheduler_unit_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_DISP  = 5'b00100,
    S_MATH  = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // take a request only in idle and when the result register is free or being read
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && (!out_valid_r || out_ready)) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        state_nxt    = S_MATH;
      end
      S_MATH: begin
        if (!stat.math_busy) state_nxt = S_WB;
      end
      S_WB: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TS_ASSERT(a_onehot, $onehot(state_r), "state not one-hot")
  `TS_ASSERT_IMP(a_fin_room, cmd.finish, (!out_valid_r || out_ready), "result overwritten")
  `TS_ASSERT_IMP(a_load_idle, cmd.load, (state_r == S_IDLE), "load outside idle")
endmodule

FILE: design/ts_div.sv
// ----------------------------------------------------------------------------
// ts_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module ts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  import ts_pkg::*;

  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] trial;

  assign busy     = (cnt_r != 7'd0);
  assign quotient = q_r;
  assign trial    = {rem_r[31:0], q_r[63]};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = 7'd64;
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - 7'd1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end
endmodule

FILE: design/ts_dp.sv
// ----------------------------------------------------------------------------
// ts_dp
// Register file, rename table, reservation stations, two units and CDB.
// ----------------------------------------------------------------------------
module ts_dp #(
  parameter int ADD_STATIONS = ts_pkg::ADD_STATIONS_DEF,
  parameter int MUL_STATIONS = ts_pkg::MUL_STATIONS_DEF,
  parameter int ARCH_REGS    = ts_pkg::ARCH_REGS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ts_pkg::ts_cmd_t  cmd,
  output ts_pkg::ts_stat_t stat,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_cmd,
  input  logic [2:0]       in_op,
  input  logic [4:0]       in_dest_reg,
  input  logic [4:0]       in_src1_reg,
  input  logic             in_src2_is_imm,
  input  logic [4:0]       in_src2_reg,
  input  logic signed [31:0] in_imm_value,
  output logic             out_issued,
  output logic             out_add_wb_valid,
  output logic [3:0]       out_add_wb_station,
  output logic signed [31:0] out_add_wb_value,
  output logic             out_mul_wb_valid,
  output logic [3:0]       out_mul_wb_station,
  output logic signed [31:0] out_mul_wb_value,
  output logic             out_all_idle,
  output logic             out_div_fault
);
  import ts_pkg::*;
  `include "tomasulo_scheduler_unit_macros.svh"

  localparam int NS = ADD_STATIONS + MUL_STATIONS;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int RW = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;

  // fold a register field onto the register file through a constant table
  function automatic logic [RW-1:0] reg_index(input logic [4:0] f);
    logic [RW-1:0] idx_map [32];
    for (int k = 0; k < 32; k++) idx_map[k] = RW'(k % ARCH_REGS);
    return idx_map[f];
  endfunction

  // configuration
  logic [7:0] lat_r [4];
  logic [3:0] acnt_r, mcnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r[0] <= 8'd1; lat_r[1] <= 8'd1; lat_r[2] <= 8'd4; lat_r[3] <= 8'd8;
      acnt_r <= 4'd8; mcnt_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADD_LAT: lat_r[0] <= cfg_wdata;
        CFG_SUB_LAT: lat_r[1] <= cfg_wdata;
        CFG_MUL_LAT: lat_r[2] <= cfg_wdata;
        CFG_DIV_LAT: lat_r[3] <= cfg_wdata;
        CFG_ADD_CNT: acnt_r <= cfg_wdata[3:0];
        CFG_MUL_CNT: mcnt_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  logic [SW:0] a_cl, m_cl, lo1, hi0, hi1;
  always_comb begin
    if (acnt_r == 4'd0) a_cl = (SW+1)'(1);
    else if ({28'd0, acnt_r} > ADD_STATIONS) a_cl = (SW+1)'(ADD_STATIONS);
    else a_cl = (SW+1)'(acnt_r);
    if (mcnt_r == 4'd0) m_cl = (SW+1)'(1);
    else if ({28'd0, mcnt_r} > MUL_STATIONS) m_cl = (SW+1)'(MUL_STATIONS);
    else m_cl = (SW+1)'(mcnt_r);
    hi0 = a_cl;
    lo1 = a_cl;
    hi1 = a_cl + m_cl;
  end

  // captured request
  logic       rq_cmd_r, rq_imm_r;
  logic [2:0] rq_op_r;
  logic [RW-1:0] rq_d_r, rq_s1_r, rq_s2_r;
  logic [31:0] rq_iv_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_cmd_r <= in_cmd; rq_op_r <= in_op; rq_imm_r <= in_src2_is_imm;
      rq_d_r  <= reg_index(in_dest_reg);
      rq_s1_r <= reg_index(in_src1_reg);
      rq_s2_r <= reg_index(in_src2_reg);
      rq_iv_r <= in_imm_value;
    end
  end

  // architectural state
  logic [31:0] regv_r [ARCH_REGS];
  logic        rtv_r [ARCH_REGS];
  logic [SW-1:0] rtg_r [ARCH_REGS];
  logic        busy_r [NS];
  logic [2:0]  sop_r [NS];
  logic [31:0] v1_r [NS], v2_r [NS];
  logic        t1v_r [NS], t2v_r [NS];
  logic [SW-1:0] t1_r [NS], t2_r [NS];

  // units
  logic        ub_r [2];
  logic [SW-1:0] ust_r [2];
  logic [7:0]  ucd_r [2];
  logic [31:0] ures_r [2];
  logic        fault_r;

  // issue search
  logic          iss_ok;
  logic [SW-1:0] iss_idx;
  always_comb begin
    logic [SW:0] lo, hi;
    iss_ok = 1'b0; iss_idx = '0;
    lo = (rq_op_r >= OP_MUL) ? lo1 : '0;
    hi = (rq_op_r >= OP_MUL) ? hi1 : hi0;
    for (int i = NS-1; i >= 0; i--) begin
      if ((SW+1)'(i) >= lo && (SW+1)'(i) < hi && !busy_r[i]) begin
        iss_ok = 1'b1; iss_idx = SW'(i);
      end
    end
    if (!rq_cmd_r || rq_op_r > OP_DIV) iss_ok = 1'b0;
  end

  // dispatch search per unit
  logic          dok [2];
  logic [SW-1:0] didx [2];
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      logic [SW:0] lo, hi;
      lo = (u == 1) ? lo1 : '0;
      hi = (u == 1) ? hi1 : hi0;
      dok[u] = 1'b0; didx[u] = '0;
      for (int i = NS-1; i >= 0; i--) begin
        if ((SW+1)'(i) >= lo && (SW+1)'(i) < hi && busy_r[i] && !t1v_r[i] && !t2v_r[i]) begin
          dok[u] = 1'b1; didx[u] = SW'(i);
        end
      end
      if (ub_r[u]) dok[u] = 1'b0;
    end
  end

  // operand registers for the math stage
  logic [2:0]  mop_r [2];
  logic [31:0] ma_r [2], mb_r [2];
  logic        pend_r [2];  // result must be formed in math stage
  logic [63:0] mprod_r;
  logic        ts_start;
  logic        div_busy;
  logic [63:0] div_q;
  logic        dstart_r;

  // add result formed directly from operand registers
  logic [31:0] add_res;
  always_comb begin
    if (mop_r[0] == OP_SUB)
      add_res = sat_add({ma_r[0][31], ma_r[0]} - {mb_r[0][31], mb_r[0]});
    else if (mop_r[0] <= OP_SUB)
      add_res = sat_add({ma_r[0][31], ma_r[0]} + {mb_r[0][31], mb_r[0]});
    else
      add_res = '0;
  end

  logic [31:0] mag_a, mag_b;
  logic        mneg;
  assign mag_a = ma_r[1][31] ? 32'(-ma_r[1]) : ma_r[1];
  assign mag_b = mb_r[1][31] ? 32'(-mb_r[1]) : mb_r[1];
  assign mneg  = ma_r[1][31] ^ mb_r[1][31];
  assign ts_start = dstart_r && (mop_r[1] == OP_DIV) && (mag_b != 32'd0);

  ts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ts_start),
    .dividend({mag_a, 16'd0} + {33'd0, mag_b[31:1]}),
    .divisor(mag_b), .busy(div_busy), .quotient(div_q)
  );

  // math stage: operands and dstart_r registered at dispatch, then the product; divider iterates
  logic mwait_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstart_r <= 1'b0; mwait_r <= 1'b0;
    end else begin
      dstart_r <= cmd.dispatch && dok[1];
      mwait_r  <= cmd.dispatch;
    end
    if (dstart_r) mprod_r <= 64'(mag_a) * 64'(mag_b);
  end
  assign stat.math_busy = ts_start || div_busy || dstart_r || mwait_r;

  logic [31:0] mul_res;
  always_comb begin
    case (mop_r[1])
      OP_MUL: mul_res = sat_mag(mneg, (mprod_r + 64'd32768) >> 16);
      OP_DIV: mul_res = (mb_r[1] == 32'd0) ? 32'd0 : sat_mag(mneg, div_q);
      default: mul_res = '0;
    endcase
  end

  // write back view
  logic wbv [2];
  logic [31:0] wbres [2];
  logic [SW-1:0] wbst [2];
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      wbv[u]  = ub_r[u] && (ucd_r[u] == 8'd0);
      wbst[u] = ust_r[u];
      wbres[u] = pend_r[u] ? ((u == 0) ? add_res : mul_res) : ures_r[u];
    end
  end

  logic any_busy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ARCH_REGS; r++) begin regv_r[r] <= '0; rtv_r[r] <= 1'b0; end
      for (int i = 0; i < NS; i++) begin
        busy_r[i] <= 1'b0; t1v_r[i] <= 1'b0; t2v_r[i] <= 1'b0;
      end
      for (int u = 0; u < 2; u++) begin
        ub_r[u] <= 1'b0; ucd_r[u] <= '0; ust_r[u] <= '0; pend_r[u] <= 1'b0;
      end
      fault_r <= 1'b0;
      out_issued <= 1'b0;
      out_add_wb_valid <= 1'b0; out_add_wb_station <= '0; out_add_wb_value <= '0;
      out_mul_wb_valid <= 1'b0; out_mul_wb_station <= '0; out_mul_wb_value <= '0;
      out_all_idle <= 1'b1; out_div_fault <= 1'b0;
    end else begin
      if (cmd.load) out_issued <= 1'b0;
      if (cmd.issue && iss_ok) begin
        out_issued <= 1'b1;
        busy_r[iss_idx] <= 1'b1;
        sop_r[iss_idx]  <= rq_op_r;
        t1v_r[iss_idx]  <= rtv_r[rq_s1_r];
        t1_r[iss_idx]   <= rtg_r[rq_s1_r];
        v1_r[iss_idx]   <= rtv_r[rq_s1_r] ? 32'd0 : regv_r[rq_s1_r];
        if (rq_imm_r) begin
          t2v_r[iss_idx] <= 1'b0; v2_r[iss_idx] <= rq_iv_r;
        end else begin
          t2v_r[iss_idx] <= rtv_r[rq_s2_r];
          t2_r[iss_idx]  <= rtg_r[rq_s2_r];
          v2_r[iss_idx]  <= rtv_r[rq_s2_r] ? 32'd0 : regv_r[rq_s2_r];
        end
        rtv_r[rq_d_r] <= 1'b1;
        rtg_r[rq_d_r] <= iss_idx;
      end
      if (cmd.dispatch) begin
        for (int u = 0; u < 2; u++) begin
          if (ub_r[u]) begin
            if (ucd_r[u] != 8'd0) ucd_r[u] <= ucd_r[u] - 8'd1;
          end else if (dok[u]) begin
            ub_r[u]   <= 1'b1;
            ust_r[u]  <= didx[u];
            pend_r[u] <= 1'b1;
            mop_r[u]  <= sop_r[didx[u]];
            ma_r[u]   <= v1_r[didx[u]];
            mb_r[u]   <= v2_r[didx[u]];
            case (sop_r[didx[u]])
              OP_SUB: ucd_r[u] <= lat_r[1];
              OP_MUL: ucd_r[u] <= lat_r[2];
              OP_DIV: ucd_r[u] <= lat_r[3];
              default: ucd_r[u] <= lat_r[0];
            endcase
          end
        end
      end
      if (cmd.finish) begin
        for (int u = 0; u < 2; u++) begin
          if (pend_r[u]) begin
            pend_r[u] <= 1'b0;
            ures_r[u] <= wbres[u];
          end
        end
        if (pend_r[1] && mop_r[1] == OP_DIV && mb_r[1] == 32'd0) fault_r <= 1'b1;
        out_div_fault <= fault_r ||
          (pend_r[1] && mop_r[1] == OP_DIV && mb_r[1] == 32'd0);
        // both units write back from the old state; on a shared station the add unit wins
        for (int u = 0; u < 2; u++) begin
          if (wbv[u]) begin
            for (int r = 0; r < ARCH_REGS; r++) begin
              if (rtv_r[r] && rtg_r[r] == wbst[u] &&
                  !(u == 1 && wbv[0] && rtg_r[r] == wbst[0])) begin
                regv_r[r] <= wbres[u]; rtv_r[r] <= 1'b0;
              end
            end
            for (int i = 0; i < NS; i++) begin
              if (t1v_r[i] && t1_r[i] == wbst[u] &&
                  !(u == 1 && wbv[0] && wbst[0] == wbst[1])) begin
                v1_r[i] <= wbres[u]; t1v_r[i] <= 1'b0;
              end
              if (t2v_r[i] && t2_r[i] == wbst[u] &&
                  !(u == 1 && wbv[0] && wbst[0] == wbst[1])) begin
                v2_r[i] <= wbres[u]; t2v_r[i] <= 1'b0;
              end
            end
            busy_r[wbst[u]] <= 1'b0;
            t1v_r[wbst[u]]  <= 1'b0;
            t2v_r[wbst[u]]  <= 1'b0;
            ub_r[u]   <= 1'b0;
            ust_r[u]  <= '0;
            pend_r[u] <= 1'b0;
          end
        end
        out_add_wb_valid   <= wbv[0];
        out_add_wb_station <= wbv[0] ? TAG_W'(wbst[0]) : '0;
        out_add_wb_value   <= wbv[0] ? wbres[0] : '0;
        out_mul_wb_valid   <= wbv[1];
        out_mul_wb_station <= wbv[1] ? TAG_W'(wbst[1]) : '0;
        out_mul_wb_value   <= wbv[1] ? wbres[1] : '0;
        out_all_idle       <= !any_busy_nxt;
      end
    end
  end

  always_comb begin
    any_busy_nxt = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (busy_r[i] && !((wbv[0] && wbst[0] == SW'(i)) || (wbv[1] && wbst[1] == SW'(i))))
        any_busy_nxt = 1'b1;
    end
  end

  `TS_ASSERT_IMP(a_ub_st, ub_r[0], busy_r[ust_r[0]], "add unit on free station")
  `TS_ASSERT_IMP(a_mb_st, ub_r[1], busy_r[ust_r[1]], "mul unit on free station")
  `TS_ASSERT_IMP(a_div_start, ts_start, !div_busy, "divider restarted while busy")
endmodule

FILE: design/tomasulo_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tomasulo_scheduler_unit
// Reservation-station scheduler with rename table and add and mul/div units.
// ----------------------------------------------------------------------------
// Each request is one scheduler tick: issue, dispatch, then write back, with
// one result per request. The tick waits in math longer when a divide with
// a nonzero divisor is dispatched in that tick: the quotient comes from a
// one-bit-per-cycle restoring divider over a 64-bit dividend. A stalled
// result holds the tick in write back. The next request is taken once the
// block is idle again and the result register is empty or being read in
// the same cycle.
module tomasulo_scheduler_unit #(
  parameter int ADD_STATIONS = ts_pkg::ADD_STATIONS_DEF,
  parameter int MUL_STATIONS = ts_pkg::MUL_STATIONS_DEF,
  parameter int ARCH_REGS    = ts_pkg::ARCH_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [2:0]  in_op,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_src1_reg,
  input  logic        in_src2_is_imm,
  input  logic [4:0]  in_src2_reg,
  input  logic signed [31:0] in_imm_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_issued,
  output logic        out_add_wb_valid,
  output logic [3:0]  out_add_wb_station,
  output logic signed [31:0] out_add_wb_value,
  output logic        out_mul_wb_valid,
  output logic [3:0]  out_mul_wb_station,
  output logic signed [31:0] out_mul_wb_value,
  output logic        out_all_idle,
  output logic        out_div_fault
);
  import ts_pkg::*;

  ts_cmd_t  cmd;
  ts_stat_t stat;

  ts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  ts_dp #(
    .ADD_STATIONS(ADD_STATIONS), .MUL_STATIONS(MUL_STATIONS), .ARCH_REGS(ARCH_REGS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_cmd(in_cmd), .in_op(in_op), .in_dest_reg(in_dest_reg),
    .in_src1_reg(in_src1_reg), .in_src2_is_imm(in_src2_is_imm),
    .in_src2_reg(in_src2_reg), .in_imm_value(in_imm_value),
    .out_issued(out_issued),
    .out_add_wb_valid(out_add_wb_valid), .out_add_wb_station(out_add_wb_station),
    .out_add_wb_value(out_add_wb_value),
    .out_mul_wb_valid(out_mul_wb_valid), .out_mul_wb_station(out_mul_wb_station),
    .out_mul_wb_value(out_mul_wb_value),
    .out_all_idle(out_all_idle), .out_div_fault(out_div_fault)
  );
endmodule

FILE: dv/tomasulo_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// tomasulo_scheduler_unit_test
// Drives scheduler ticks through the request channel and compares each
// per-tick result with a cycle-free predictor of stations, renaming and units.
// ----------------------------------------------------------------------------
module tomasulo_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ts_pkg::*;

  localparam int NST = 16;
  localparam int WDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic [2:0] in_op = '0;
  logic [4:0] in_dest_reg = '0, in_src1_reg = '0, in_src2_reg = '0;
  logic in_src2_is_imm = 1'b0;
  logic signed [31:0] in_imm_value = '0;
  logic out_valid, out_ready = 1'b0;
  logic out_issued, out_add_wb_valid, out_mul_wb_valid, out_all_idle, out_div_fault;
  logic [3:0] out_add_wb_station, out_mul_wb_station;
  logic signed [31:0] out_add_wb_value, out_mul_wb_value;

  tomasulo_scheduler_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic issued;
    logic add_v; logic [3:0] add_s; logic [31:0] add_d;
    logic mul_v; logic [3:0] mul_s; logic [31:0] mul_d;
    logic idle; logic fault;
  } tick_out_t;

  // predictor state
  logic [7:0] lat_add, lat_sub, lat_mul, lat_div;
  logic [3:0] cnt_add, cnt_mul;
  logic [31:0] reg_val[32];
  logic [4:0] reg_tag[32];     // bit 4 = renamed
  logic st_busy[NST];
  logic [2:0] st_op[NST];
  logic [31:0] st_v1[NST], st_v2[NST];
  logic [4:0] st_t1[NST], st_t2[NST];
  logic u_busy[2];
  logic [3:0] u_st[2];
  logic [7:0] u_cd[2];
  logic [31:0] u_res[2];
  logic fault_seen;

  tick_out_t expected_ticks[$];
  int errors = 0;
  int accepted = 0;
  bit hold_off = 1'b0;

  function automatic logic [31:0] alu_result(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    longint sa, sb, s;
    logic neg;
    longint unsigned ma, mb, m;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    neg = a[31] ^ b[31];
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    if (op == OP_ADD || op == OP_ADDI || op == OP_SUB) begin
      s = (op == OP_SUB) ? sa - sb : sa + sb;
      if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -64'sd2147483648) return 32'h8000_0000;
      return s[31:0];
    end
    if (op == OP_MUL) m = (ma * mb + 32768) >> 16;
    else if (mb == 0) begin
      fault_seen = 1'b1;
      return '0;
    end else m = ((ma << 16) + mb / 2) / mb;
    if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic int clamp_cnt(logic [3:0] c);
    return c < 1 ? 1 : (c > 8 ? 8 : int'(c));
  endfunction

  function automatic void model_reset();
    lat_add = 1; lat_sub = 1; lat_mul = 4; lat_div = 8;
    cnt_add = 8; cnt_mul = 8;
    fault_seen = 1'b0;
    for (int i = 0; i < 32; i++) begin
      reg_val[i] = '0; reg_tag[i] = '0;
    end
    for (int i = 0; i < NST; i++) begin
      st_busy[i] = 0; st_op[i] = '0; st_v1[i] = '0; st_v2[i] = '0;
      st_t1[i] = '0; st_t2[i] = '0;
    end
    for (int u = 0; u < 2; u++) begin
      u_busy[u] = 0; u_st[u] = '0; u_cd[u] = '0; u_res[u] = '0;
    end
  endfunction

  function automatic void read_src(logic [4:0] r, output logic [31:0] v, output logic [4:0] t);
    if (reg_tag[r][4]) begin v = '0; t = reg_tag[r]; end
    else begin v = reg_val[r]; t = '0; end
  endfunction

  function automatic tick_out_t predict_tick(logic cmd, logic [2:0] op, logic [4:0] dst,
      logic [4:0] s1, logic imm, logic [4:0] s2, logic [31:0] iv);
    tick_out_t o;
    int lo, hi, slot, a, m;
    logic [4:0] tg;
    o = '0;
    a = clamp_cnt(cnt_add);
    m = clamp_cnt(cnt_mul);
    if (cmd && op <= OP_DIV) begin
      lo = (op >= OP_MUL) ? a : 0;
      hi = (op >= OP_MUL) ? a + m : a;
      slot = -1;
      for (int i = lo; i < hi; i++)
        if (slot < 0 && !st_busy[i]) slot = i;
      if (slot >= 0) begin
        read_src(s1, st_v1[slot], st_t1[slot]);
        if (imm) begin st_v2[slot] = iv; st_t2[slot] = '0; end
        else read_src(s2, st_v2[slot], st_t2[slot]);
        reg_tag[dst] = {1'b1, 4'(slot)};
        st_busy[slot] = 1; st_op[slot] = op;
        o.issued = 1;
      end
    end
    for (int u = 0; u < 2; u++) begin
      if (u_busy[u]) begin
        if (u_cd[u] != 0) u_cd[u]--;
      end else begin
        lo = u ? a : 0;
        hi = u ? a + m : a;
        for (int i = lo; i < hi; i++)
          if (!u_busy[u] && st_busy[i] && !st_t1[i][4] && !st_t2[i][4]) begin
            u_busy[u] = 1; u_st[u] = 4'(i);
            case (st_op[i])
              OP_SUB: u_cd[u] = lat_sub;
              OP_MUL: u_cd[u] = lat_mul;
              OP_DIV: u_cd[u] = lat_div;
              default: u_cd[u] = lat_add;
            endcase
            u_res[u] = alu_result(st_op[i], st_v1[i], st_v2[i]);
          end
      end
    end
    for (int u = 0; u < 2; u++) begin
      if (u_busy[u] && u_cd[u] == 0) begin
        tg = {1'b1, u_st[u]};
        for (int i = 0; i < 32; i++)
          if (reg_tag[i] == tg) begin reg_val[i] = u_res[u]; reg_tag[i] = '0; end
        for (int i = 0; i < NST; i++) begin
          if (st_t1[i] == tg) begin st_v1[i] = u_res[u]; st_t1[i] = '0; end
          if (st_t2[i] == tg) begin st_v2[i] = u_res[u]; st_t2[i] = '0; end
        end
        st_busy[u_st[u]] = 0;
        if (u == 0) begin o.add_v = 1; o.add_s = u_st[u]; o.add_d = u_res[u]; end
        else begin o.mul_v = 1; o.mul_s = u_st[u]; o.mul_d = u_res[u]; end
        u_busy[u] = 0; u_st[u] = '0; u_res[u] = '0;
      end
    end
    o.idle = 1;
    for (int i = 0; i < NST; i++) if (st_busy[i]) o.idle = 0;
    o.fault = fault_seen;
    return o;
  endfunction

  // valid stays high into the next request when no gap is drawn
  task automatic send_tick(logic cmd, logic [2:0] op, logic [4:0] dst, logic [4:0] s1,
      logic imm, logic [4:0] s2, logic [31:0] iv);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_cmd <= cmd; in_op <= op; in_dest_reg <= dst;
    in_src1_reg <= s1; in_src2_is_imm <= imm; in_src2_reg <= s2; in_imm_value <= iv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_ticks.insert(expected_ticks.size(), predict_tick(cmd, op, dst, s1, imm, s2, iv));
    accepted++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ADD_LAT: lat_add = val;
      CFG_SUB_LAT: lat_sub = val;
      CFG_MUL_LAT: lat_mul = val;
      CFG_DIV_LAT: lat_div = val;
      CFG_ADD_CNT: cnt_add = val[3:0];
      CFG_MUL_CNT: cnt_mul = val[3:0];
      default: ;
    endcase
  endtask

  // wait for all results, then drain the block with empty ticks
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
    for (int i = 0; i < 5000 && !(st_busy.or() == 0 && !u_busy[0] && !u_busy[1]); i++) begin
      send_tick(0, OP_ADD, 0, 0, 0, 0, 0);
      if (expected_ticks.size() > 0 && expected_ticks[$].idle && !u_busy[0] && !u_busy[1])
        break;
    end
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_instr(int n, int hot_regs);
    logic [2:0] op;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      op = (r == 9) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_tick($urandom_range(0, 5) != 0, op, 5'($urandom_range(0, hot_regs)),
                5'($urandom_range(0, hot_regs)), $urandom_range(0, 2) == 0,
                5'($urandom_range(0, hot_regs)),
                $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 2)) << 16 : $urandom());
    end
  endtask

  task automatic test_directed();
    send_tick(1, OP_ADDI, 1, 0, 1, 0, 32'h7FFF_FFFF);
    send_tick(1, OP_ADDI, 2, 0, 1, 0, 32'h8000_0000);
    send_tick(1, OP_ADD, 3, 1, 0, 1, 0);
    send_tick(1, OP_SUB, 4, 2, 0, 1, 0);
    send_tick(1, OP_MUL, 5, 1, 0, 1, 0);
    send_tick(1, OP_MUL, 6, 2, 0, 1, 0);
    send_tick(1, OP_DIV, 7, 1, 1, 0, 32'h0000_0000);
    send_tick(1, OP_DIV, 8, 2, 1, 0, 32'hFFFF_FFFF);
    send_tick(1, OP_DIV, 9, 1, 1, 0, 32'h0003_0000);
    send_tick(1, OP_ADDI, 9, 9, 1, 0, 32'h0001_0000);
    send_tick(1, OP_MUL, 10, 10, 1, 0, 32'hFFFF_8000);
    send_tick(1, 3'd5, 11, 31, 0, 31, 32'h1234_5678);
    send_tick(1, 3'd7, 31, 31, 1, 31, 32'hFFFF_FFFF);
    send_tick(0, OP_DIV, 31, 31, 1, 31, 32'hFFFF_FFFF);
    send_tick(1, OP_SUB, 31, 31, 0, 31, 0);
    for (int i = 0; i < 10; i++) send_tick(1, OP_MUL, 5'(12 + i), 5, 0, 6, 0);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [7:0] lats[4] = '{8'd0, 8'd255, 8'd3, 8'd1};
    logic [3:0] cnts[4] = '{4'd0, 4'd15, 4'd1, 4'd3};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_ADD_LAT, p == 1 ? 8'd20 : lats[p]);
      write_reg(CFG_SUB_LAT, lats[(p + 1) % 4] % 8'd30);
      write_reg(CFG_MUL_LAT, lats[(p + 2) % 4] % 8'd30);
      write_reg(CFG_DIV_LAT, p == 1 ? 8'd255 : lats[(p + 3) % 4]);
      write_reg(CFG_ADD_CNT, cnts[p]);
      write_reg(CFG_MUL_CNT, cnts[(p + 1) % 4]);
      random_instr(p == 1 ? 60 : 150, p[0] ? 3 : 31);
      drain();
    end
    write_reg(CFG_ADD_LAT, 1); write_reg(CFG_SUB_LAT, 2);
    write_reg(CFG_MUL_LAT, 4); write_reg(CFG_DIV_LAT, 8);
    write_reg(CFG_ADD_CNT, 8); write_reg(CFG_MUL_CNT, 8);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    random_instr(30, 7);
    drain();
  endtask

  task automatic test_random();
    random_instr(500, 7);
    random_instr(200, 31);
    drain();
  endtask

  // receiver: random stall per result, plus one long hold-off
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 7);
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tick_out_t exp_t;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_t = expected_ticks.pop_front();
        if (out_issued !== exp_t.issued) begin
          $error("issued exp %0d got %0d", exp_t.issued, out_issued); errors++; end
        if (out_add_wb_valid !== exp_t.add_v) begin
          $error("add_wb_valid exp %0d got %0d", exp_t.add_v, out_add_wb_valid); errors++; end
        if (out_add_wb_station !== exp_t.add_s) begin
          $error("add_wb_station exp %0d got %0d", exp_t.add_s, out_add_wb_station); errors++; end
        if (out_add_wb_value !== exp_t.add_d) begin
          $error("add_wb_value exp %h got %h", exp_t.add_d, out_add_wb_value); errors++; end
        if (out_mul_wb_valid !== exp_t.mul_v) begin
          $error("mul_wb_valid exp %0d got %0d", exp_t.mul_v, out_mul_wb_valid); errors++; end
        if (out_mul_wb_station !== exp_t.mul_s) begin
          $error("mul_wb_station exp %0d got %0d", exp_t.mul_s, out_mul_wb_station); errors++; end
        if (out_mul_wb_value !== exp_t.mul_d) begin
          $error("mul_wb_value exp %h got %h", exp_t.mul_d, out_mul_wb_value); errors++; end
        if (out_all_idle !== exp_t.idle) begin
          $error("all_idle exp %0d got %0d", exp_t.idle, out_all_idle); errors++; end
        if (out_div_fault !== exp_t.fault) begin
          $error("div_fault exp %0d got %0d", exp_t.fault, out_div_fault); errors++; end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/ts_pkg.sv
design/ts_ctrl.sv
design/ts_div.sv
design/ts_dp.sv
design/tomasulo_scheduler_unit.sv
dv/tomasulo_scheduler_unit_test.sv
